@@ rtl/trfp_pkg.sv @@
// package for the text record frame parser
// holds sizes, character codes, result kinds and the end-of-block label table
// no dependencies
package trfp_pkg;

	localparam int BLOCK_MAX   = 512;
	localparam int LABEL_LIMIT = 32;

	localparam int BYTE_W = 8;
	localparam int KEEP_W = 6;
	localparam int KIND_W = 3;
	localparam int LPOS_W = $clog2(LABEL_LIMIT + 1);
	localparam int BLEN_W = $clog2(BLOCK_MAX + 1);
	localparam int END_LABEL_LEN = 8;

	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(26);

	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;

	typedef enum logic [KIND_W-1:0] {
		K_LABEL     = 3'd0,
		K_VALUE     = 3'd1,
		K_LABEL_END = 3'd2,
		K_VALUE_END = 3'd3,
		K_BLOCK_END = 3'd4
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		kind_t             kind;
		logic              ok;
		logic              bad;
	} result_t;

	function automatic logic [BYTE_W-1:0] end_label_char(input logic [2:0] idx);
		logic [BYTE_W-1:0] c;
		case (idx)
			3'd0:    c = 8'h43;
			3'd1:    c = 8'h68;
			3'd2:    c = 8'h65;
			3'd3:    c = 8'h63;
			3'd4:    c = 8'h6b;
			3'd5:    c = 8'h73;
			3'd6:    c = 8'h75;
			default: c = 8'h6d;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/text_record_frame_parser.sv @@
// text record frame parser: label/value records with a modulo-256 block sum
// each result is registered; throughput 1 byte per cycle while skid is empty;
// the parse state machine updates in the cycle the byte is accepted and the
// result goes to an output register backed by one skid entry
// arst_n clears the parser state and output valid flags, sets label_keep (26)
// depends on trfp_pkg
module text_record_frame_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [trfp_pkg::KEEP_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [trfp_pkg::BYTE_W-1:0]    rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [trfp_pkg::BYTE_W-1:0]    out_byte,
	output logic [trfp_pkg::KIND_W-1:0]    kind,
	output logic                           block_ok,
	output logic                           block_malformed
);

	typedef enum logic [2:0] {
		PH_WAIT_CR,
		PH_WAIT_LF,
		PH_LABEL,
		PH_VALUE,
		PH_CKSUM
	} phase_t;

	phase_t                          phase_q, phase_n;
	logic [trfp_pkg::BYTE_W-1:0]     sum_q, sum_add, sum_n;
	logic [trfp_pkg::LPOS_W-1:0]     lpos_q, lpos_n, keep;
	logic                            match_q, match_n;
	logic                            mal_q, mal_n;
	logic [trfp_pkg::BLEN_W-1:0]     len_q, len_add, len_n;
	logic [trfp_pkg::KEEP_W-1:0]     keep_q;

	logic                            r_emit, blk_end;
	trfp_pkg::result_t               r;
	trfp_pkg::result_t               out_q, skid_q;
	logic                            out_valid_q, skid_valid_q;
	logic                            in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;

	assign keep = (keep_q > trfp_pkg::KEEP_W'(trfp_pkg::LABEL_LIMIT))
		? trfp_pkg::LPOS_W'(trfp_pkg::LABEL_LIMIT) : trfp_pkg::LPOS_W'(keep_q);

	always_comb begin
		sum_add = sum_q + rx_byte;
		len_add = len_q + trfp_pkg::BLEN_W'(1);
		sum_n   = sum_add;
		len_n   = len_add;
		phase_n = phase_q;
		lpos_n  = lpos_q;
		match_n = match_q;
		mal_n   = mal_q;
		r_emit  = 1'b0;
		blk_end = 1'b0;
		r.data  = '0;
		r.kind  = trfp_pkg::K_LABEL;
		r.ok    = 1'b0;
		r.bad   = 1'b0;
		unique case (phase_q)
			PH_WAIT_CR: begin
				if (rx_byte == trfp_pkg::CH_CR) begin
					phase_n = PH_WAIT_LF;
				end else begin
					mal_n = 1'b1;
				end
			end
			PH_WAIT_LF: begin
				if (rx_byte == trfp_pkg::CH_LF) begin
					phase_n = PH_LABEL;
					lpos_n  = '0;
					match_n = 1'b1;
				end else if (rx_byte != trfp_pkg::CH_CR) begin
					mal_n   = 1'b1;
					phase_n = PH_WAIT_CR;
				end
			end
			PH_LABEL: begin
				if (rx_byte == trfp_pkg::CH_TAB) begin
					if (match_q && lpos_q == trfp_pkg::LPOS_W'(trfp_pkg::END_LABEL_LEN)) begin
						phase_n = PH_CKSUM;
					end else begin
						phase_n = PH_VALUE;
						r.kind  = trfp_pkg::K_LABEL_END;
						r_emit  = 1'b1;
					end
				end else if (rx_byte == trfp_pkg::CH_CR) begin
					mal_n   = 1'b1;
					phase_n = PH_WAIT_LF;
				end else begin
					if (lpos_q >= trfp_pkg::LPOS_W'(trfp_pkg::END_LABEL_LEN)
						|| rx_byte != trfp_pkg::end_label_char(lpos_q[2:0])) begin
						match_n = 1'b0;
					end
					if (lpos_q < keep) begin
						r.data = rx_byte;
						r.kind = trfp_pkg::K_LABEL;
						r_emit = 1'b1;
					end
					if (lpos_q < trfp_pkg::LPOS_W'(trfp_pkg::LABEL_LIMIT)) begin
						lpos_n = lpos_q + trfp_pkg::LPOS_W'(1);
					end
				end
			end
			PH_VALUE: begin
				if (rx_byte == trfp_pkg::CH_CR) begin
					phase_n = PH_WAIT_LF;
					r.kind  = trfp_pkg::K_VALUE_END;
				end else begin
					r.data = rx_byte;
					r.kind = trfp_pkg::K_VALUE;
				end
				r_emit = 1'b1;
			end
			PH_CKSUM: begin
				blk_end = 1'b1;
				r_emit  = 1'b1;
				r.data  = '0;
				r.kind  = trfp_pkg::K_BLOCK_END;
				r.ok    = (sum_add == '0);
				r.bad   = mal_q;
			end
			default: begin
				phase_n = PH_WAIT_CR;
			end
		endcase
		if (!blk_end && len_add >= trfp_pkg::BLEN_W'(trfp_pkg::BLOCK_MAX)) begin
			blk_end = 1'b1;
			r_emit  = 1'b1;
			r.data  = '0;
			r.kind  = trfp_pkg::K_BLOCK_END;
			r.ok    = 1'b0;
			r.bad   = 1'b1;
		end else if (!blk_end && mal_n) begin
			r_emit = 1'b0;
		end
		if (blk_end) begin
			sum_n   = '0;
			len_n   = '0;
			mal_n   = 1'b0;
			phase_n = PH_WAIT_CR;
			lpos_n  = '0;
			match_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT_CR;
			sum_q        <= '0;
			lpos_q       <= '0;
			match_q      <= 1'b1;
			mal_q        <= 1'b0;
			len_q        <= '0;
			keep_q       <= trfp_pkg::KEEP_RESET;
			out_q        <= '0;
			skid_q       <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				keep_q <= cfg_data;
			end
			if (in_fire) begin
				phase_q <= phase_n;
				sum_q   <= sum_n;
				lpos_q  <= lpos_n;
				match_q <= match_n;
				mal_q   <= mal_n;
				len_q   <= len_n;
			end
			// output register holds while stalled, new result parks in skid
			if (out_valid_q && !out_ready) begin
				if (in_fire && r_emit) begin
					skid_q       <= r;
					skid_valid_q <= 1'b1;
				end
			end else if (skid_valid_q) begin
				out_q        <= skid_q;
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_q       <= r;
				out_valid_q <= in_fire && r_emit;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = out_q.data;
	assign kind            = out_q.kind;
	assign block_ok        = out_q.ok;
	assign block_malformed = out_q.bad;

endmodule
